// ===== design/sai_pkg.sv =====
// Shared constants, codes and types for the sorted array insertion block.
// Used by the sequencer, the queue and the top module of the block and by its port checker.
package sai_pkg;

   localparam int CAPACITY = 64;
   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int DATA_W = 32;
   localparam int IDX_W = 6;
   localparam int OP_W = 2;

   // Result queue in front of the response port.
   localparam int OUTQ_DEPTH = 4;
   localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
   localparam int OUTQ_LVL_W = $clog2(OUTQ_DEPTH + 1);
   localparam int OUTQ_SUM_W = OUTQ_LVL_W + 1;

   localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   localparam logic STATUS_OK = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SEARCH = 5'b00010,
      ST_SHIFT  = 5'b00100,
      ST_EMIT   = 5'b01000,
      ST_REJECT = 5'b10000
   } state_type;

   typedef struct packed {
      logic                     valid;
      logic signed [DATA_W-1:0] value;
      logic [IDX_W-1:0]         index;
      logic                     last;
      logic                     status;
   } result_type;

endpackage

// ===== design/sai_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module sai_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/sai_outq.sv =====
// Small result queue that drives the response port and decouples it from the sequencer.
// Depends on sai_pkg.
module sai_outq (
   input  logic                               clock,
   input  logic                               reset,
   input  sai_pkg::result_type                push,
   output logic [sai_pkg::OUTQ_LVL_W-1:0]     level,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [sai_pkg::DATA_W-1:0]  rsp_element_value,
   output logic [sai_pkg::IDX_W-1:0]          rsp_element_index,
   output logic                               rsp_last_flag,
   output logic                               rsp_status
);

   sai_pkg::result_type                entries_ff [sai_pkg::OUTQ_DEPTH];
   logic [sai_pkg::OUTQ_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [sai_pkg::OUTQ_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [sai_pkg::OUTQ_LVL_W-1:0]     level_ff, level_in;
   logic                               pop;
   sai_pkg::result_type                head;

   assign rsp_valid = (level_ff != '0);
   assign pop = rsp_valid && !rsp_stall;
   assign head = entries_ff[rd_ptr_ff];
   assign level = level_ff;

   assign rsp_element_value = head.value;
   assign rsp_element_index = head.index;
   assign rsp_last_flag = head.last;
   assign rsp_status = head.status;

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == sai_pkg::OUTQ_PTR_W'(sai_pkg::OUTQ_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == sai_pkg::OUTQ_PTR_W'(sai_pkg::OUTQ_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      level_in = level_ff + sai_pkg::OUTQ_LVL_W'(push.valid)
                 - sai_pkg::OUTQ_LVL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entries_ff[wr_ptr_ff] <= push;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         level_ff <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         level_ff <= level_in;
      end
   end

endmodule

// ===== design/sai_seq.sv =====
// Sequencer that searches, shifts and reads out the element store held in one RAM.
// Depends on sai_pkg and sai_ram.
module sai_seq (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [sai_pkg::OP_W-1:0]           req_operation,
   input  logic signed [sai_pkg::DATA_W-1:0]  req_item_value,
   input  logic [sai_pkg::OUTQ_LVL_W-1:0]     outq_level,
   output sai_pkg::result_type                push
);

   sai_pkg::state_type                 state_ff, state_in;
   logic [sai_pkg::CNT_W-1:0]          count_ff, count_in;
   logic [sai_pkg::CNT_W-1:0]          ptr_ff, ptr_in;
   logic [sai_pkg::CNT_W-1:0]          pos_ff, pos_in;
   logic signed [sai_pkg::DATA_W-1:0]  value_ff, value_in;
   logic                               rd_pend_ff, rd_pend_in;
   logic [sai_pkg::ADDR_W-1:0]         rd_pos_ff, rd_pos_in;
   logic                               emit_pend_ff, emit_pend_in;
   logic [sai_pkg::ADDR_W-1:0]         emit_idx_ff, emit_idx_in;
   logic                               emit_last_ff, emit_last_in;

   logic                               wr_en;
   logic [sai_pkg::ADDR_W-1:0]         wr_addr;
   logic [sai_pkg::DATA_W-1:0]         wr_data;
   logic                               rd_en;
   logic [sai_pkg::ADDR_W-1:0]         rd_addr;
   logic [sai_pkg::DATA_W-1:0]         rd_data;

   logic                               full;
   logic [sai_pkg::CNT_W-1:0]          count_m1;
   logic [sai_pkg::CNT_W-1:0]          ptr_m1;
   logic [sai_pkg::OUTQ_SUM_W-1:0]     inflight;
   logic                               room;
   logic                               greater;

   sai_ram #(
      .WIDTH(sai_pkg::DATA_W),
      .DEPTH(sai_pkg::CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign full = (count_ff >= sai_pkg::CNT_W'(sai_pkg::CAPACITY));
   assign count_m1 = count_ff - 1'b1;
   assign ptr_m1 = ptr_ff - 1'b1;
   assign greater = ($signed(rd_data) > value_ff);
   assign req_stall = (state_ff != sai_pkg::ST_IDLE);

   // A read issued now lands in the queue in the next cycle, so count it against the free space.
   assign inflight = {1'b0, outq_level} + sai_pkg::OUTQ_SUM_W'(emit_pend_ff);
   assign room = (inflight < sai_pkg::OUTQ_SUM_W'(sai_pkg::OUTQ_DEPTH));

   always_comb begin
      push.valid = 1'b0;
      push.value = '0;
      push.index = '0;
      push.last = 1'b1;
      push.status = sai_pkg::STATUS_FULL;
      if (emit_pend_ff) begin
         push.valid = 1'b1;
         push.value = rd_data;
         push.index = sai_pkg::IDX_W'(emit_idx_ff);
         push.last = emit_last_ff;
         push.status = sai_pkg::STATUS_OK;
      end else if ((state_ff == sai_pkg::ST_REJECT) && room) begin
         push.valid = 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ptr_in = ptr_ff;
      pos_in = pos_ff;
      value_in = value_ff;
      rd_pend_in = rd_pend_ff;
      rd_pos_in = rd_pos_ff;
      emit_pend_in = 1'b0;
      emit_idx_in = emit_idx_ff;
      emit_last_in = emit_last_ff;
      wr_en = 1'b0;
      wr_addr = count_ff[sai_pkg::ADDR_W-1:0];
      wr_data = req_item_value;
      rd_en = 1'b0;
      rd_addr = ptr_ff[sai_pkg::ADDR_W-1:0];

      case (state_ff)
         sai_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (req_operation)
                  sai_pkg::OP_LOAD: begin
                     if (full) begin
                        state_in = sai_pkg::ST_REJECT;
                     end else begin
                        wr_en = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  sai_pkg::OP_INSERT: begin
                     if (full) begin
                        state_in = sai_pkg::ST_REJECT;
                     end else begin
                        value_in = req_item_value;
                        ptr_in = '0;
                        pos_in = '0;
                        rd_pend_in = 1'b0;
                        state_in = (count_ff == '0) ? sai_pkg::ST_SHIFT : sai_pkg::ST_SEARCH;
                     end
                  end
                  sai_pkg::OP_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Reads run one per cycle from the bottom; the compare works on the word
         // returned for the previous address.
         sai_pkg::ST_SEARCH: begin
            if (rd_pend_ff && greater) begin
               pos_in = sai_pkg::CNT_W'(rd_pos_ff);
               ptr_in = count_ff;
               rd_pend_in = 1'b0;
               state_in = sai_pkg::ST_SHIFT;
            end else if (rd_pend_ff && (rd_pos_ff == count_m1[sai_pkg::ADDR_W-1:0])) begin
               pos_in = count_ff;
               ptr_in = count_ff;
               rd_pend_in = 1'b0;
               state_in = sai_pkg::ST_SHIFT;
            end else begin
               rd_en = (ptr_ff < count_ff);
               rd_addr = ptr_ff[sai_pkg::ADDR_W-1:0];
               rd_pend_in = rd_en;
               rd_pos_in = ptr_ff[sai_pkg::ADDR_W-1:0];
               if (rd_en) begin
                  ptr_in = ptr_ff + 1'b1;
               end
            end
         end

         // Walks down from the top: read entry j-1 now, write it to entry j next cycle.
         sai_pkg::ST_SHIFT: begin
            rd_pend_in = 1'b0;
            if (rd_pend_ff) begin
               wr_en = 1'b1;
               wr_addr = rd_pos_ff + 1'b1;
               wr_data = rd_data;
            end
            if (ptr_ff > pos_ff) begin
               rd_en = 1'b1;
               rd_addr = ptr_m1[sai_pkg::ADDR_W-1:0];
               rd_pend_in = 1'b1;
               rd_pos_in = ptr_m1[sai_pkg::ADDR_W-1:0];
               ptr_in = ptr_m1;
            end else if (!rd_pend_ff) begin
               wr_en = 1'b1;
               wr_addr = pos_ff[sai_pkg::ADDR_W-1:0];
               wr_data = value_ff;
               count_in = count_ff + 1'b1;
               ptr_in = '0;
               state_in = sai_pkg::ST_EMIT;
            end
         end

         sai_pkg::ST_EMIT: begin
            if (room) begin
               rd_en = 1'b1;
               rd_addr = ptr_ff[sai_pkg::ADDR_W-1:0];
               emit_pend_in = 1'b1;
               emit_idx_in = ptr_ff[sai_pkg::ADDR_W-1:0];
               emit_last_in = (ptr_ff == count_m1);
               ptr_in = ptr_ff + 1'b1;
               if (ptr_ff == count_m1) begin
                  state_in = sai_pkg::ST_IDLE;
               end
            end
         end

         sai_pkg::ST_REJECT: begin
            if (room) begin
               state_in = sai_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = sai_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sai_pkg::ST_IDLE;
         count_ff <= '0;
         rd_pend_ff <= 1'b0;
         emit_pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rd_pend_ff <= rd_pend_in;
         emit_pend_ff <= emit_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      pos_ff <= pos_in;
      value_ff <= value_in;
      rd_pos_ff <= rd_pos_in;
      emit_idx_ff <= emit_idx_in;
      emit_last_ff <= emit_last_in;
   end

endmodule

// ===== design/sorted_array_insert.sv =====
// Sorted array insertion block: a store of up to 64 signed 32-bit elements in one
// RAM with a registered read. A clear or unused code, or a load into a store that is
// not full, gives no word. An insert into a store of n elements first searches for
// the place p (one RAM read per cycle, compare on the returned word), then moves the
// tail up (read and write back one entry per cycle) and reads the n+1 result words
// out. The single RAM read port serves all three steps. A load or insert into a full
// store gives one word with the full status. Result words pass through a four-word
// queue, so a stalled response side holds the sequencer back only once that queue
// fills. The store needs no clearing after reset.
// Depends on sai_pkg, sai_seq and sai_outq.
module sorted_array_insert (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [sai_pkg::OP_W-1:0]           req_operation,
   input  logic signed [sai_pkg::DATA_W-1:0]  req_item_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [sai_pkg::DATA_W-1:0]  rsp_element_value,
   output logic [sai_pkg::IDX_W-1:0]          rsp_element_index,
   output logic                               rsp_last_flag,
   output logic                               rsp_status
);

   sai_pkg::result_type                push;
   logic [sai_pkg::OUTQ_LVL_W-1:0]     outq_level;

   sai_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_item_value (req_item_value),
      .outq_level     (outq_level),
      .push           (push)
   );

   sai_outq u_outq (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .level             (outq_level),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_element_value (rsp_element_value),
      .rsp_element_index (rsp_element_index),
      .rsp_last_flag     (rsp_last_flag),
      .rsp_status        (rsp_status)
   );

endmodule

// ===== design/sai_checker.sv =====
// Port-level checker for the sorted array insertion block, bound to its top level.
// Depends on sai_pkg and sorted_array_insert.
module sai_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic signed [sai_pkg::DATA_W-1:0]  rsp_element_value,
   input logic [sai_pkg::IDX_W-1:0]          rsp_element_index,
   input logic                               rsp_last_flag,
   input logic                               rsp_status
);

   // Nothing is queued for the response side right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response word shown right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_element_value)
         && $stable(rsp_element_index) && $stable(rsp_last_flag) && $stable(rsp_status))
      else $error("stalled response word changed");

   // A rejected request gives a single word with empty payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == sai_pkg::STATUS_FULL) |->
         rsp_last_flag && (rsp_element_index == '0) && (rsp_element_value == '0))
      else $error("full-status word is not a lone empty word");

   // The top position can only be the last element of a readout.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_element_index == sai_pkg::IDX_W'(sai_pkg::CAPACITY - 1)) |->
         rsp_last_flag)
      else $error("word at the top position is not marked last");

endmodule

bind sorted_array_insert sai_checker u_sai_checker (.*);

// ===== test/sorted_array_insert_tb.sv =====
// Self-checking testbench for sorted_array_insert: drives load, insert, clear and unused
// code words, predicts every emitted element and compares the response port field by field.
// Depends on sai_pkg and the sorted_array_insert RTL.
module sorted_array_insert_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [sai_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int ITEM_TARGET = 370;
   localparam int QUIET_ITEMS = 40;
   localparam int LONG_HOLD_CYCLES = 500;
   localparam int DRAIN_CYCLES = 4 * sai_pkg::CAPACITY + 20;
   localparam longint CYCLE_LIMIT = 2000000;

   typedef struct {
      logic signed [sai_pkg::DATA_W-1:0] value;
      logic [sai_pkg::IDX_W-1:0]         index;
      logic                              last;
      logic                              status;
   } element_word_type;

   // Mirrors the sorted store and holds the element words still to come out.
   class array_tracker_type;
      logic signed [sai_pkg::DATA_W-1:0] store [sai_pkg::CAPACITY];
      int count;
      element_word_type pending_words[$];
      int accepted, ignored, loads, inserts, clears, rejects;
      int words_checked, errors;

      function void note_request(logic [sai_pkg::OP_W-1:0] op,
                                 logic signed [sai_pkg::DATA_W-1:0] v);
         int pos;
         int j;
         element_word_type w;
         accepted++;
         case (op)
            sai_pkg::OP_CLEAR: begin
               count = 0;
               clears++;
            end
            sai_pkg::OP_LOAD, sai_pkg::OP_INSERT: begin
               if (count >= sai_pkg::CAPACITY) begin
                  w.value = '0;
                  w.index = '0;
                  w.last = 1'b1;
                  w.status = sai_pkg::STATUS_FULL;
                  pending_words.push_back(w);
                  rejects++;
               end else if (op == sai_pkg::OP_LOAD) begin
                  store[count] = v;
                  count++;
                  loads++;
               end else begin
                  // The new value goes after every element that is not greater.
                  pos = 0;
                  while (pos < count && !(store[pos] > v)) pos++;
                  for (j = count; j > pos; j--) store[j] = store[j-1];
                  store[pos] = v;
                  count++;
                  inserts++;
                  for (j = 0; j < count; j++) begin
                     w.value = store[j];
                     w.index = j[sai_pkg::IDX_W-1:0];
                     w.last = (j == count - 1);
                     w.status = sai_pkg::STATUS_OK;
                     pending_words.push_back(w);
                  end
               end
            end
            default: ignored++;
         endcase
      endfunction

      function void compare_field(string name, logic signed [sai_pkg::DATA_W:0] expected_val,
                                  logic signed [sai_pkg::DATA_W:0] actual_val);
         if (actual_val !== expected_val) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d",
                     $time, name, expected_val, actual_val);
            errors++;
         end
      endfunction

      function void check_word(logic signed [sai_pkg::DATA_W-1:0] value,
                               logic [sai_pkg::IDX_W-1:0] index,
                               logic last, logic status);
         element_word_type w;
         words_checked++;
         if (pending_words.size() == 0) begin
            $display("%0t: unexpected word: expected none, actual value %0d index %0d",
                     $time, value, index);
            errors++;
            return;
         end
         w = pending_words.pop_front();
         compare_field("element_value", w.value, value);
         compare_field("element_index", w.index, index);
         compare_field("last_flag", w.last, last);
         compare_field("status", w.status, status);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [sai_pkg::OP_W-1:0] req_operation = sai_pkg::OP_CLEAR;
   logic signed [sai_pkg::DATA_W-1:0] req_item_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [sai_pkg::DATA_W-1:0] rsp_element_value;
   logic [sai_pkg::IDX_W-1:0] rsp_element_index;
   logic rsp_last_flag;
   logic rsp_status;

   array_tracker_type tracker = new;
   bit quiet_tail = 1'b0;
   longint cycles = 0;

   sorted_array_insert i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_item_value    (req_item_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_element_value (rsp_element_value),
      .rsp_element_index (rsp_element_index),
      .rsp_last_flag     (rsp_last_flag),
      .rsp_status        (rsp_status)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Timeout after %0d cycles with %0d words outstanding.",
               cycles, tracker.pending_words.size());
      $display("sorted_array_insert verification failed");
      $finish;
   end

   function automatic logic signed [sai_pkg::DATA_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return 32'sd0;
         3: return -32'sd1;
         4, 5: return $signed($urandom_range(0, 20)) - 32'sd10;
         default: return $signed($urandom);
      endcase
   endfunction

   task automatic send_word(logic [sai_pkg::OP_W-1:0] op,
                            logic signed [sai_pkg::DATA_W-1:0] v);
      req_valid <= 1'b1;
      req_operation <= op;
      req_item_value <= v;
      do @(posedge clock); while (req_stall);
      tracker.note_request(op, v);
      quiet_tail = (tracker.accepted - tracker.ignored) >= ITEM_TARGET - QUIET_ITEMS;
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   task automatic run_directed();
      send_word(sai_pkg::OP_CLEAR, pick_value());
      send_word(sai_pkg::OP_INSERT, 32'sd5);
      send_word(OP_UNUSED, -32'sd1);
      send_word(sai_pkg::OP_LOAD, 32'sd7);
      send_word(sai_pkg::OP_INSERT, 32'sh8000_0000);
      send_word(sai_pkg::OP_INSERT, 32'sh7fff_ffff);
      send_word(sai_pkg::OP_INSERT, 32'sd5);
      send_word(sai_pkg::OP_INSERT, 32'sd6);
      send_word(sai_pkg::OP_INSERT, -32'sd1);
      // An out-of-order load; the next insert must still scan from the front.
      send_word(sai_pkg::OP_LOAD, -32'sd2);
      send_word(sai_pkg::OP_INSERT, 32'sd0);
      send_word(sai_pkg::OP_CLEAR, 32'sh7fff_ffff);
      send_word(OP_UNUSED, 32'sd0);
      send_word(sai_pkg::OP_INSERT, 32'sh7fff_ffff);
      send_word(sai_pkg::OP_INSERT, 32'sh7fff_ffff);
      send_word(sai_pkg::OP_INSERT, 32'sh8000_0000);
      send_word(sai_pkg::OP_CLEAR, 32'sd0);
   endtask

   task automatic run_random();
      int seg;
      int kind;
      int loads_wanted;
      int inserts_wanted;
      int i;
      int vals[$];
      seg = 0;
      while (tracker.accepted - tracker.ignored < ITEM_TARGET) begin
         kind = $urandom_range(0, 9);
         // Two sequences fill the store and then push past capacity.
         if (seg == 0 || seg == 15) kind = 0;
         if (kind <= 7) begin
            send_word(sai_pkg::OP_CLEAR, pick_value());
            vals.delete();
            if (seg == 0 || seg == 15) loads_wanted = sai_pkg::CAPACITY - $urandom_range(1, 3);
            else loads_wanted = $urandom_range(0, 12);
            for (i = 0; i < loads_wanted; i++) vals.push_back(pick_value());
            if (kind <= 5) vals.sort();
            foreach (vals[n]) send_word(sai_pkg::OP_LOAD, vals[n]);
            if (seg == 0 || seg == 15) inserts_wanted = sai_pkg::CAPACITY - loads_wanted + 1;
            else inserts_wanted = $urandom_range(1, 4);
            for (i = 0; i < inserts_wanted; i++) send_word(sai_pkg::OP_INSERT, pick_value());
            if (seg == 0 || seg == 15) send_word(sai_pkg::OP_LOAD, pick_value());
         end else if (kind == 8) begin
            for (i = $urandom_range(1, 6); i > 0; i--)
               send_word(logic'($urandom_range(0, 3)) ? OP_UNUSED : OP_UNUSED, pick_value());
         end else begin
            for (i = $urandom_range(1, 3); i > 0; i--)
               send_word(sai_pkg::OP_INSERT, pick_value());
         end
         seg++;
      end
   endtask

   // Response side: checks each accepted word, then stalls in bursts, with one long hold.
   initial begin
      int hold_left;
      int burst_left;
      bit long_hold_done;
      bit stall_next;
      hold_left = 0;
      burst_left = 0;
      long_hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && !rsp_stall)
            tracker.check_word(rsp_element_value, rsp_element_index, rsp_last_flag,
                               rsp_status);
         if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
         end else if (!long_hold_done && tracker.accepted >= 40) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD_CYCLES - 1;
            stall_next = 1'b1;
         end else if (burst_left > 0) begin
            burst_left--;
            stall_next = 1'b1;
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(1, 17) - 1;
            stall_next = 1'b1;
         end else begin
            stall_next = 1'b0;
         end
         rsp_stall <= stall_next;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      run_random();
      req_valid <= 1'b0;
      while (tracker.pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d loads, %0d inserts, %0d clears, %0d full rejects, %0d unused codes.",
               tracker.loads, tracker.inserts, tracker.clears, tracker.rejects,
               tracker.ignored);
      $display("Checked %0d result words over %0d cycles, %0d mismatches.",
               tracker.words_checked, cycles, tracker.errors);
      if (tracker.errors == 0) begin
         $display("sorted_array_insert verification clean");
      end else begin
         $display("sorted_array_insert verification failed");
      end
      $finish;
   end

endmodule
